/* sv/svps_pkg.sv */
// shared types, constants and reset values for the servo pulse sequencer
// no dependencies; used by svps_sweep and servo_pulse_sequencer_with_sweep
package svps_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int SLOT_W       = $clog2(NUM_CHANNELS + 1);
  localparam int LINE_W       = 8;
  localparam int SHOWN_W      = 4;
  localparam int WIDTH_W      = 16;
  localparam int TRI_W        = 13;
  localparam int STEP_W       = 8;
  localparam int SWING_W      = 12;
  localparam int PERIOD_W     = 20;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_WIDTH  = 3'd0,
    REG_SWEEP_STEP    = 3'd1,
    REG_SWEEP_HIGH    = 3'd2,
    REG_SWEEP_LOW     = 3'd3,
    REG_SWING_OFFSET  = 3'd4,
    REG_IDLE_WIDTH    = 3'd5,
    REG_SYNC_GAP      = 3'd6,
    REG_UPDATE_PERIOD = 3'd7
  } cfg_reg_t;

  localparam logic [WIDTH_W-1:0]         CENTER_RST = 16'd2750;
  localparam logic [STEP_W-1:0]          STEP_RST   = 8'd4;
  localparam logic signed [TRI_W-1:0]    HIGH_RST   = 13'sd200;
  localparam logic signed [TRI_W-1:0]    LOW_RST    = -13'sd200;
  localparam logic [SWING_W-1:0]         SWING_RST  = 12'd400;
  localparam logic [WIDTH_W-1:0]         IDLE_RST   = 16'd1500;
  localparam logic [WIDTH_W-1:0]         GAP_RST    = 16'd6000;
  localparam logic [PERIOD_W-1:0]        PERIOD_RST = 20'd20000;
  localparam logic signed [TRI_W-1:0]    HOLD_RST   = -13'sd100;

  typedef struct packed {
    logic [STEP_W-1:0]   step;
    logic [TRI_W-1:0]    high;
    logic [TRI_W-1:0]    low;
    logic [SWING_W-1:0]  swing;
    logic [PERIOD_W-1:0] period;
  } sweep_cfg_t;

  // sweep values after the current tick's update
  typedef struct packed {
    logic [TRI_W-1:0] triangle;
    logic [TRI_W-1:0] hold;
  } sweep_val_t;

endpackage

/* sv/servo_pulse_sequencer_with_sweep.sv */
// servo pulse sequencer top: config registers, slot sequencer, result register
// depends on svps_pkg and svps_sweep
// a result is presented the cycle after its tick transfer
// throughput: one tick per clock while out_stall is low; set by the single result
//   register, which takes a new tick while its current result is being taken
// reset (rst_n low, synchronous): registers return to defaults, frame restarts
//   at slot 0 on the first tick, no result is pending
module servo_pulse_sequencer_with_sweep (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_tick,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [svps_pkg::LINE_W-1:0]       out_servo_lines,
  output logic [svps_pkg::SHOWN_W-1:0]      out_active_slot,
  output logic signed [svps_pkg::TRI_W-1:0] out_sweep_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [svps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import svps_pkg::*;

  localparam logic [SLOT_W-1:0] GAP_SLOT = SLOT_W'(NUM_CHANNELS);

  // configuration registers
  logic [WIDTH_W-1:0]  center_r, idle_r, gap_r;
  logic [STEP_W-1:0]   step_r;
  logic [TRI_W-1:0]    high_r, low_r;
  logic [SWING_W-1:0]  swing_r;
  logic [PERIOD_W-1:0] period_r;

  // slot sequencer
  logic [SLOT_W-1:0]  slot_idx_r, slot_idx_nxt;
  logic [WIDTH_W-1:0] slot_cnt_r, slot_cnt_nxt;
  logic [WIDTH_W-1:0] slot_lim_r, slot_lim_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;

  // result register
  logic                    out_valid_r;
  logic [LINE_W-1:0]       out_lines_r;
  logic [SHOWN_W-1:0]      out_slot_r;
  logic signed [TRI_W-1:0] out_tri_r;

  logic          in_xfer, advance;
  sweep_cfg_t    sweep_cfg;
  sweep_val_t    sweep_val;
  logic [WIDTH_W-1:0] width_swept, width_hold, width_sel;
  logic [SLOT_W-1:0]  shown;

  function automatic logic [WIDTH_W-1:0] sat_width(input logic [WIDTH_W-1:0] base,
                                                   input logic [TRI_W-1:0] ofs);
    logic signed [WIDTH_W+1:0] sum;
    sum = $signed({2'b00, base}) + $signed({{(WIDTH_W+2-TRI_W){ofs[TRI_W-1]}}, ofs});
    if (sum[WIDTH_W+1]) begin
      return '0;
    end else if (sum[WIDTH_W]) begin
      return '1;
    end else begin
      return sum[WIDTH_W-1:0];
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_xfer   = in_valid & ~in_stall;
  assign advance   = in_xfer & in_tick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= CENTER_RST;
      step_r   <= STEP_RST;
      high_r   <= HIGH_RST;
      low_r    <= LOW_RST;
      swing_r  <= SWING_RST;
      idle_r   <= IDLE_RST;
      gap_r    <= GAP_RST;
      period_r <= PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_WIDTH:  center_r <= cfg_data[WIDTH_W-1:0];
        REG_SWEEP_STEP:    step_r   <= cfg_data[STEP_W-1:0];
        REG_SWEEP_HIGH:    high_r   <= cfg_data[TRI_W-1:0];
        REG_SWEEP_LOW:     low_r    <= cfg_data[TRI_W-1:0];
        REG_SWING_OFFSET:  swing_r  <= cfg_data[SWING_W-1:0];
        REG_IDLE_WIDTH:    idle_r   <= cfg_data[WIDTH_W-1:0];
        REG_SYNC_GAP:      gap_r    <= cfg_data[WIDTH_W-1:0];
        REG_UPDATE_PERIOD: period_r <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign sweep_cfg.step   = step_r;
  assign sweep_cfg.high   = high_r;
  assign sweep_cfg.low    = low_r;
  assign sweep_cfg.swing  = swing_r;
  assign sweep_cfg.period = period_r;

  svps_sweep u_sweep (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cfg     (sweep_cfg),
    .val_nxt (sweep_val)
  );

  // a slot starting on this tick sees the sweep values after this tick's step
  assign width_swept = sat_width(center_r, sweep_val.triangle);
  assign width_hold  = sat_width(center_r, sweep_val.hold);

  always_comb begin
    if (slot_idx_r >= GAP_SLOT) begin
      width_sel = gap_r;
    end else if (int'(slot_idx_r) == 0 || int'(slot_idx_r) == 2) begin
      width_sel = width_swept;
    end else if (int'(slot_idx_r) == 1) begin
      width_sel = width_hold;
    end else begin
      width_sel = idle_r;
    end
  end

  always_comb begin
    slot_idx_nxt = slot_idx_r;
    slot_cnt_nxt = slot_cnt_r;
    slot_lim_nxt = slot_lim_r;
    line_nxt     = line_r;
    if (advance) begin
      if (slot_cnt_r >= slot_lim_r) begin
        if (slot_idx_r < GAP_SLOT && int'(slot_idx_r) < LINE_W) begin
          line_nxt = LINE_W'(1) << slot_idx_r;
        end else begin
          line_nxt = '0;
        end
        slot_lim_nxt = width_sel;
        slot_cnt_nxt = WIDTH_W'(1);
        slot_idx_nxt = (slot_idx_r >= GAP_SLOT) ? '0 : slot_idx_r + SLOT_W'(1);
      end else begin
        slot_cnt_nxt = slot_cnt_r + WIDTH_W'(1);
      end
    end
  end

  // slot index points at the next slot, so the one on show is one back
  assign shown = (slot_idx_nxt == '0) ? GAP_SLOT : slot_idx_nxt - SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_idx_r  <= '0;
      slot_cnt_r  <= '0;
      slot_lim_r  <= '0;
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_idx_r <= slot_idx_nxt;
      slot_cnt_r <= slot_cnt_nxt;
      slot_lim_r <= slot_lim_nxt;
      line_r     <= line_nxt;
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_lines_r <= line_nxt;
      out_slot_r  <= SHOWN_W'(shown);
      out_tri_r   <= $signed(sweep_val.triangle);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_servo_lines = out_lines_r;
  assign out_active_slot = out_slot_r;
  assign out_sweep_value = out_tri_r;

`ifndef SYNTHESIS
  a_lines_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(line_r))
    else $error("more than one servo line driven");

  a_counter_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    slot_cnt_r <= slot_lim_r || slot_cnt_r == WIDTH_W'(1))
    else $error("slot counter ran past its limit");

  a_gap_lines_low: assert property (@(posedge clk) disable iff (!rst_n)
    slot_idx_r == '0 |-> line_r == '0)
    else $error("line driven during sync gap");

  a_result_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("no result after a tick transfer");
`endif

endmodule

/* sv/svps_sweep.sv */
// triangle sweep: update period counter, triangle value, direction, hold offset
// depends on svps_pkg
module svps_sweep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  svps_pkg::sweep_cfg_t cfg,
  output svps_pkg::sweep_val_t val_nxt
);
  import svps_pkg::*;

  localparam logic signed [TRI_W+1:0] TRI_MAX = 15'sd4095;
  localparam logic signed [TRI_W+1:0] TRI_MIN = -15'sd4096;

  logic [PERIOD_W-1:0]      period_r, period_nxt;
  logic signed [TRI_W-1:0]  tri_r, tri_nxt;
  logic                     falling_r, falling_nxt;
  logic signed [TRI_W-1:0]  hold_r, hold_nxt;

  logic [PERIOD_W-1:0]      period_eff;
  logic [PERIOD_W-1:0]      period_inc;
  logic signed [TRI_W+1:0]  tri_ext, step_ext, tri_sum;
  logic signed [TRI_W-1:0]  tri_sat, swing_pos;

  assign period_eff = (cfg.period == '0) ? PERIOD_W'(1) : cfg.period;
  assign period_inc = period_r + PERIOD_W'(1);
  assign tri_ext    = {{2{tri_r[TRI_W-1]}}, tri_r};
  assign step_ext   = $signed({(TRI_W+2-STEP_W)'(0), cfg.step});
  assign tri_sum    = falling_r ? tri_ext - step_ext : tri_ext + step_ext;
  assign swing_pos  = $signed({1'b0, cfg.swing});

  always_comb begin
    if (tri_sum > TRI_MAX) begin
      tri_sat = TRI_MAX[TRI_W-1:0];
    end else if (tri_sum < TRI_MIN) begin
      tri_sat = TRI_MIN[TRI_W-1:0];
    end else begin
      tri_sat = tri_sum[TRI_W-1:0];
    end
  end

  always_comb begin
    period_nxt  = period_r;
    tri_nxt     = tri_r;
    falling_nxt = falling_r;
    hold_nxt    = hold_r;
    if (advance) begin
      if (period_inc >= period_eff) begin
        period_nxt = '0;
        tri_nxt    = tri_sat;
        if (tri_sat > $signed(cfg.high)) begin
          falling_nxt = 1'b1;
          hold_nxt    = swing_pos;
        end
        // lower turn applied last so it wins on crossed bounds
        if (tri_sat < $signed(cfg.low)) begin
          falling_nxt = 1'b0;
          hold_nxt    = -swing_pos;
        end
      end else begin
        period_nxt = period_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= '0;
      tri_r     <= '0;
      falling_r <= 1'b0;
      hold_r    <= HOLD_RST;
    end else begin
      period_r  <= period_nxt;
      tri_r     <= tri_nxt;
      falling_r <= falling_nxt;
      hold_r    <= hold_nxt;
    end
  end

  assign val_nxt.triangle = tri_nxt;
  assign val_nxt.hold     = hold_nxt;

`ifndef SYNTHESIS
  a_turn_down_positive: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(falling_r) |-> !hold_r[TRI_W-1])
    else $error("hold offset negative after downward turn");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(tri_r) && $stable(period_r) && $stable(hold_r))
    else $error("sweep state moved without a tick");

  a_period_reset_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (tri_nxt != tri_r) |=> period_r == '0)
    else $error("period counter not cleared on sweep step");
`endif

endmodule
